FILE: design/sfi_pkg.sv
`default_nettype none
package sfi_pkg;

  localparam int MAX_ATOMS  = 256;
  localparam int INDEX_BITS = 8;
  localparam int ADDR_W     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ATOMS + 1);
  localparam int DRAIN_CYC  = 10;
  localparam int DCNT_W     = 4;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [2:0] REG_HH   = 3'd0;
  localparam logic [2:0] REG_KK   = 3'd1;
  localparam logic [2:0] REG_LL   = 3'd2;
  localparam logic [2:0] REG_HK   = 3'd3;
  localparam logic [2:0] REG_HL   = 3'd4;
  localparam logic [2:0] REG_KL   = 3'd5;
  localparam logic [2:0] REG_QMAX = 3'd6;

  typedef struct packed {
    logic [1:0]        action;
    logic [15:0]       atom_x;
    logic [15:0]       atom_y;
    logic [15:0]       atom_z;
    logic [15:0]       atom_weight;
    logic signed [7:0] index_h;
    logic signed [7:0] index_k;
    logic signed [7:0] index_l;
  } in_item_t;

  typedef struct packed {
    logic [63:0] intensity;
    logic        within_q;
    logic        status;
    logic [8:0]  atoms_held;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        hh;
    logic [31:0]        kk;
    logic [31:0]        ll;
    logic signed [31:0] hk;
    logic signed [31:0] hl;
    logic signed [31:0] kl;
    logic [47:0]        qmax;
  } metric_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic fin1;
    logic fin2;
    logic emit;
  } sfi_cmd_t;

  typedef struct packed {
    logic empty;
    logic walk_last;
  } sfi_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN1,
    ST_FIN2,
    ST_RESP
  } sfi_state_t;

endpackage
`default_nettype wire

FILE: design/sfi_ram.sv
`default_nettype none
module sfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/sfi_ctrl.sv
`default_nettype none
module sfi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       action,
  input  wire sfi_pkg::sfi_stat_t stat,
  output sfi_pkg::sfi_cmd_t     cmd,
  output logic                  busy
);
  import sfi_pkg::*;

  sfi_state_t        state_r, state_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    dcnt_nxt  = (state_r == ST_DRAIN) ? dcnt_r + DCNT_W'(1) : '0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (action == ACT_QUERY) begin
            state_nxt = stat.empty ? ST_DRAIN : ST_WALK;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (stat.walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (dcnt_r == DCNT_W'(DRAIN_CYC - 1)) state_nxt = ST_FIN1;
      end
      ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/sfi_datapath.sv
`default_nettype none
module sfi_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfi_pkg::in_item_t  in_data,
  input  wire sfi_pkg::metric_t   metric,
  input  wire sfi_pkg::sfi_cmd_t  cmd,
  output sfi_pkg::sfi_stat_t      stat,
  output sfi_pkg::out_item_t      out_data,
  output logic                    out_valid
);
  import sfi_pkg::*;

  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;
  localparam int IP_W  = 2 * INDEX_BITS;
  localparam int ACC_W = 35 + ADDR_W;
  localparam int MAG_W = ACC_W - 15;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } atom_t;

  // Horner step: c - (a * t2) >> 14.
  function automatic logic [31:0] hstep(input logic [31:0] a, input logic [14:0] t2,
                                        input logic [31:0] c);
    logic [46:0] pr;
    pr = 47'(a) * 47'(t2);
    return c - pr[45:14];
  endfunction

  function automatic logic signed [INDEX_BITS-1:0] sext_idx(input logic [7:0] v);
    logic [19:0] z;
    z = {12'b0, v};
    return signed'(z[INDEX_BITS-1:0]);
  endfunction

  // Item latch and table control.
  logic [CNT_W-1:0]             count_r;
  logic [ADDR_W-1:0]            addr_r;
  logic                         is_query_r, drop_r;
  logic signed [INDEX_BITS-1:0] h_r, k_r, l_r;
  logic                         full, ram_we;
  atom_t                        wr_atom, rd_atom;

  assign full    = (count_r == CNT_W'(MAX_ATOMS));
  assign ram_we  = cmd.load && (in_data.action == ACT_APPEND) && !full;
  assign wr_atom = '{w: in_data.atom_weight, z: in_data.atom_z,
                     y: in_data.atom_y, x: in_data.atom_x};

  assign stat.empty     = (count_r == '0);
  assign stat.walk_last = ((CNT_W'(addr_r) + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      addr_r     <= '0;
      is_query_r <= 1'b0;
      drop_r     <= 1'b0;
    end else if (cmd.load) begin
      addr_r     <= '0;
      is_query_r <= (in_data.action == ACT_QUERY);
      drop_r     <= (in_data.action == ACT_APPEND) && full;
      if (in_data.action == ACT_CLEAR) count_r <= '0;
      else if (ram_we) count_r <= count_r + CNT_W'(1);
    end else if (cmd.issue) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r <= sext_idx(in_data.index_h);
      k_r <= sext_idx(in_data.index_k);
      l_r <= sext_idx(in_data.index_l);
    end
  end

  sfi_ram #(.WIDTH(64), .DEPTH(MAX_ATOMS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (wr_atom),
    .raddr (addr_r),
    .rdata (rd_atom)
  );

  // Per-atom pipeline: phase, t2, four Horner steps, final product,
  // weighting, accumulation. Lane a evaluates S(r), lane b S(16384-r).
  logic        v_d_r, v_p_r, v_t_r, v_f_r, v_m_r;
  logic [3:0]  v_h_r;
  logic [15:0] hu, ku, lu, p_nxt;
  logic [15:0] p_r, w_p_r;
  logic [14:0] ra_nxt, rb_nxt;
  logic [29:0] sqa, sqb;

  logic [14:0] ra_r [5], rb_r [5], t2a_r [5], t2b_r [5];
  logic [1:0]  q_r  [6];
  logic [15:0] w_r  [6];
  logic [31:0] ha_r [4], hb_r [4];
  logic [46:0] fa, fb;
  logic [16:0] sa_r, sb_r;
  logic signed [17:0] sn, cs;
  logic signed [33:0] pre_r, pim_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;

  assign hu    = 16'(h_r);
  assign ku    = 16'(k_r);
  assign lu    = 16'(l_r);
  assign p_nxt = hu * rd_atom.x + ku * rd_atom.y + lu * rd_atom.z;

  assign ra_nxt = {1'b0, p_r[13:0]};
  assign rb_nxt = 15'd16384 - ra_nxt;
  assign sqa    = 30'(ra_nxt) * 30'(ra_nxt);
  assign sqb    = 30'(rb_nxt) * 30'(rb_nxt);
  assign fa     = 47'(ha_r[3]) * 47'(ra_r[4]);
  assign fb     = 47'(hb_r[3]) * 47'(rb_r[4]);

  always_comb begin
    case (q_r[5])
      2'd0: begin
        sn = $signed({1'b0, sa_r});
        cs = $signed({1'b0, sb_r});
      end
      2'd1: begin
        sn = $signed({1'b0, sb_r});
        cs = -$signed({1'b0, sa_r});
      end
      2'd2: begin
        sn = -$signed({1'b0, sa_r});
        cs = -$signed({1'b0, sb_r});
      end
      default: begin
        sn = -$signed({1'b0, sb_r});
        cs = $signed({1'b0, sa_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
      v_p_r <= 1'b0;
      v_t_r <= 1'b0;
      v_h_r <= '0;
      v_f_r <= 1'b0;
      v_m_r <= 1'b0;
    end else begin
      v_d_r <= cmd.issue;
      v_p_r <= v_d_r;
      v_t_r <= v_p_r;
      v_h_r <= {v_h_r[2:0], v_t_r};
      v_f_r <= v_h_r[3];
      v_m_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    w_p_r    <= rd_atom.w;
    ra_r[0]  <= ra_nxt;
    rb_r[0]  <= rb_nxt;
    t2a_r[0] <= sqa[28:14];
    t2b_r[0] <= sqb[28:14];
    q_r[0]   <= p_r[15:14];
    w_r[0]   <= w_p_r;
    ha_r[0]  <= hstep(C9, t2a_r[0], C7);
    hb_r[0]  <= hstep(C9, t2b_r[0], C7);
    ha_r[1]  <= hstep(ha_r[0], t2a_r[1], C5);
    hb_r[1]  <= hstep(hb_r[0], t2b_r[1], C5);
    ha_r[2]  <= hstep(ha_r[1], t2a_r[2], C3);
    hb_r[2]  <= hstep(hb_r[1], t2b_r[2], C3);
    ha_r[3]  <= hstep(ha_r[2], t2a_r[3], C1);
    hb_r[3]  <= hstep(hb_r[2], t2b_r[3], C1);
    for (int i = 1; i < 5; i++) begin
      ra_r[i]  <= ra_r[i-1];
      rb_r[i]  <= rb_r[i-1];
      t2a_r[i] <= t2a_r[i-1];
      t2b_r[i] <= t2b_r[i-1];
    end
    for (int i = 1; i < 6; i++) begin
      q_r[i] <= q_r[i-1];
      w_r[i] <= w_r[i-1];
    end
    // Clamp the quarter sine to 1.0 in Q15.
    sa_r  <= (fa[46:29] > 18'd32768) ? 17'd32768 : fa[45:29];
    sb_r  <= (fb[46:29] > 18'd32768) ? 17'd32768 : fb[45:29];
    pre_r <= $signed({18'b0, w_r[5]}) * 34'(cs);
    pim_r <= $signed({18'b0, w_r[5]}) * 34'(sn);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v_m_r) begin
      acc_re_r <= acc_re_r + ACC_W'(pre_r);
      acc_im_r <= acc_im_r + ACC_W'(pim_r);
    end
  end

  // |G|^2 runs one term a cycle while the atoms stream.
  logic [2:0]             g_step_r;
  logic                   g_run_r;
  logic signed [IP_W-1:0] ip_hh_r, ip_kk_r, ip_ll_r, ip_hk_r, ip_hl_r, ip_kl_r;
  logic signed [IP_W-1:0] ip_sel;
  logic signed [32:0]     m_sel;
  logic                   dbl;
  logic signed [33+IP_W-1:0] term;
  logic signed [63:0]     g_r;

  always_comb begin
    ip_sel = ip_hh_r;
    m_sel  = $signed({1'b0, metric.hh});
    dbl    = 1'b0;
    case (g_step_r)
      3'd2: begin
        ip_sel = ip_kk_r;
        m_sel  = $signed({1'b0, metric.kk});
      end
      3'd3: begin
        ip_sel = ip_ll_r;
        m_sel  = $signed({1'b0, metric.ll});
      end
      3'd4: begin
        ip_sel = ip_hk_r;
        m_sel  = 33'(metric.hk);
        dbl    = 1'b1;
      end
      3'd5: begin
        ip_sel = ip_hl_r;
        m_sel  = 33'(metric.hl);
        dbl    = 1'b1;
      end
      3'd6: begin
        ip_sel = ip_kl_r;
        m_sel  = 33'(metric.kl);
        dbl    = 1'b1;
      end
      default: ;
    endcase
    term = (33+IP_W)'(m_sel) * (33+IP_W)'(ip_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_run_r  <= 1'b0;
      g_step_r <= '0;
    end else if (cmd.load) begin
      g_run_r  <= 1'b1;
      g_step_r <= '0;
    end else if (g_run_r) begin
      g_step_r <= g_step_r + 3'd1;
      if (g_step_r == 3'd6) g_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r <= '0;
    end else if (g_run_r) begin
      if (g_step_r == 3'd0) begin
        ip_hh_r <= h_r * h_r;
        ip_kk_r <= k_r * k_r;
        ip_ll_r <= l_r * l_r;
        ip_hk_r <= h_r * k_r;
        ip_hl_r <= h_r * l_r;
        ip_kl_r <= k_r * l_r;
      end else begin
        g_r <= g_r + (dbl ? (64'(term) <<< 1) : 64'(term));
      end
    end
  end

  // Finishing: round each magnitude by 15 bits, square, sum.
  logic [ACC_W-1:0] abs_re, abs_im, rnd_re, rnd_im;
  logic [MAG_W-1:0] mag_re_r, mag_im_r;
  logic [2*MAG_W-1:0] sq_re_r, sq_im_r;
  logic             nonzero, in_range;
  logic [CNT_W+8:0] held_ext;

  assign abs_re   = acc_re_r[ACC_W-1] ? ACC_W'(-acc_re_r) : ACC_W'(acc_re_r);
  assign abs_im   = acc_im_r[ACC_W-1] ? ACC_W'(-acc_im_r) : ACC_W'(acc_im_r);
  assign rnd_re   = abs_re + ACC_W'(16384);
  assign rnd_im   = abs_im + ACC_W'(16384);
  assign nonzero  = (h_r != '0) || (k_r != '0) || (l_r != '0);
  assign in_range = nonzero && (g_r < $signed({16'b0, metric.qmax}));
  assign held_ext = {9'b0, count_r};

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      mag_re_r <= rnd_re[ACC_W-1:15];
      mag_im_r <= rnd_im[ACC_W-1:15];
    end
    if (cmd.fin2) begin
      sq_re_r <= mag_re_r * mag_re_r;
      sq_im_r <= mag_im_r * mag_im_r;
    end
    if (cmd.emit) begin
      out_data.intensity  <= is_query_r ? (64'(sq_re_r) + 64'(sq_im_r)) : 64'd0;
      out_data.within_q   <= is_query_r && in_range;
      out_data.status     <= drop_r;
      out_data.atoms_held <= held_ext[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit;
  end
endmodule
`default_nettype wire

FILE: design/structure_factor_intensity_unit.sv
`default_nettype none
// Structure-factor intensity unit.
//
// The host issues one command transaction by raising start while busy is
// low; in_data carries the action (clear table, append atom, query
// reflection) with its atom and Miller index fields. Every command yields
// exactly one result transaction on out_data, marked by out_valid for one
// cycle. The receiver cannot stall, so results are never held back.
//
// Clear and append go from acceptance straight to the response state,
// whose emit command registers out_valid. A query streams every stored
// atom (up to 256), one per cycle, through a single phase, sine and
// multiply-accumulate pipeline, then drains and finishes: it rounds and
// squares the two magnitudes, and the response state sums the squares.
// The next command is accepted in the cycle of out_valid.
//
// The APB-style port holds the reciprocal metric and the momentum limit
// at byte addresses 8*i; write it only while the unit is idle.
// Reset (rst_n low, synchronous) empties the atom table and zeroes the port
// registers; stored atoms are not cleared, as only live entries are read.
module structure_factor_intensity_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sfi_pkg::in_item_t in_data,
  output logic                   out_valid,
  output sfi_pkg::out_item_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [5:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import sfi_pkg::*;

  metric_t   metric_r;
  sfi_cmd_t  cmd;
  sfi_stat_t stat;
  logic      wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // Configuration registers; a write to an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HH:   metric_r.hh   <= pwdata[31:0];
        REG_KK:   metric_r.kk   <= pwdata[31:0];
        REG_LL:   metric_r.ll   <= pwdata[31:0];
        REG_HK:   metric_r.hk   <= signed'(pwdata[31:0]);
        REG_HL:   metric_r.hl   <= signed'(pwdata[31:0]);
        REG_KL:   metric_r.kl   <= signed'(pwdata[31:0]);
        REG_QMAX: metric_r.qmax <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HH:   prdata = {32'b0, metric_r.hh};
      REG_KK:   prdata = {32'b0, metric_r.kk};
      REG_LL:   prdata = {32'b0, metric_r.ll};
      REG_HK:   prdata = {32'b0, metric_r.hk};
      REG_HL:   prdata = {32'b0, metric_r.hl};
      REG_KL:   prdata = {32'b0, metric_r.kl};
      REG_QMAX: prdata = {16'b0, metric_r.qmax};
      default:  prdata = '0;
    endcase
  end

  sfi_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  sfi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .metric    (metric_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

  // A result is a single-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // An accepted command makes the unit busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a command");

  // A dropped append never reports a reflection inside the limit.
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && out_data.within_q))
    else $error("status and within_q both set");

  // A result only follows a strobe command from the controller.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit))
    else $error("result without emit command");
endmodule
`default_nettype wire
